// File: rtl/core/rle_pkg.sv
// Shared types and constants for the run-length token stream decoder.
// Used by rle_token_stream_decoder, its port checker, the fill checker and the testbench; no dependencies.
package rle_pkg;

  // width of the kept run count, at most the result count width
  localparam int unsigned CountBits = 20;
  localparam int unsigned CountW    = 20;
  localparam int unsigned LitW      = 12;

  // tag byte fields
  localparam int unsigned TagRunBit   = 7;
  localparam int unsigned TagZeroBit  = 6;
  localparam int unsigned TagWideBit  = 5;
  localparam int unsigned TagShortBit = 4;

  // register value for the compression mode after reset
  localparam logic CompressedModeRst = 1'b1;

  // one input transfer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } rle_in_t;

  // one result transfer
  typedef struct packed {
    logic [7:0]        fill_value;
    logic [CountW-1:0] repeat_count;
    logic              stream_done;
    logic              stream_error;
  } rle_out_t;

endpackage

// File: rtl/core/rle_token_stream_decoder.sv
// Top level of the run-length token stream decoder: record parser between an
// input register and a result register. Depends on rle_pkg.
//
// Each byte is held in the input register, and any result it gives is then registered in the result register.
// Throughput: one byte per cycle; the input stalls only while a shown result is stalled.
// Reset (rst_ni low, asynchronous): parser at the tag phase, compressed mode
// on, both pipeline registers empty.
module rle_token_stream_decoder
  import rle_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rle_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rle_out_t out_data_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic     cfg_data_i
);

  typedef enum logic [2:0] {
    PhTag     = 3'd0,
    PhValue   = 3'd1,
    PhCntMid  = 3'd2,
    PhCntLow  = 3'd3,
    PhLitLow  = 3'd4,
    PhLitData = 3'd5
  } phase_e;

  logic                 mode_q;
  logic                 s1_valid_q;
  rle_in_t              s1_data_q;
  logic                 out_valid_q, out_valid_d;
  rle_out_t             out_data_q, out_data_d;
  phase_e               phase_q, phase_d;
  logic [7:0]           tag_q, tag_d;
  logic [CountBits-1:0] acc_q, acc_d;
  logic [7:0]           run_q, run_d;
  logic [LitW-1:0]      lit_q, lit_d;

  logic out_ready;
  logic advance;

  // handshake control
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_ready;
  assign in_stall_o  = s1_valid_q && !out_ready;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // record parser on the registered byte
  always_comb begin
    logic [7:0]        b;
    logic              av_go;
    logic [7:0]        av_tag;
    logic [3:0]        nib;
    logic [CountW-1:0] wide;
    logic              have;
    logic [7:0]        o_val;
    logic [CountW-1:0] o_cnt;
    logic              err;

    b       = s1_data_q.data_byte;
    av_go   = 1'b0;
    av_tag  = tag_q;
    nib     = 4'd0;
    wide    = '0;
    have    = 1'b0;
    o_val   = 8'd0;
    o_cnt   = '0;
    err     = 1'b0;
    phase_d = phase_q;
    tag_d   = tag_q;
    acc_d   = acc_q;
    run_d   = run_q;
    lit_d   = lit_q;

    if (mode_q) begin
      case (phase_q)
        PhValue: begin
          run_d = b;
          av_go = 1'b1;
        end
        PhCntMid: begin
          wide    = CountW'(acc_q) | {4'd0, b, 8'd0};
          acc_d   = wide[CountBits-1:0];
          phase_d = PhCntLow;
        end
        PhCntLow: begin
          wide  = CountW'(acc_q) | {12'd0, b};
          acc_d = wide[CountBits-1:0];
          if (acc_d != '0) begin
            have  = 1'b1;
            o_val = run_q;
            o_cnt = CountW'(acc_d);
          end
          phase_d = PhTag;
        end
        PhLitLow: begin
          lit_d   = lit_q | {4'd0, b};
          phase_d = (lit_d != '0) ? PhLitData : PhTag;
        end
        PhLitData: begin
          have  = 1'b1;
          o_val = b;
          o_cnt = CountW'(1);
          lit_d = lit_q - LitW'(1);
          if (lit_d == '0) begin
            phase_d = PhTag;
          end
        end
        default: begin
          tag_d = b;
          if (b[TagRunBit]) begin
            run_d = 8'd0;
            if (b[TagZeroBit]) begin
              av_go  = 1'b1;
              av_tag = b;
            end else begin
              phase_d = PhValue;
            end
          end else if (b[TagShortBit]) begin
            lit_d   = {b[3:0], 8'd0};
            phase_d = PhLitLow;
          end else begin
            lit_d   = {8'd0, b[3:0]};
            phase_d = (b[3:0] != 4'd0) ? PhLitData : PhTag;
          end
        end
      endcase

      // count fields that follow the run value, or the tag of a zero run
      if (av_go) begin
        nib = av_tag[3:0];
        if (av_tag[TagWideBit]) begin
          wide    = {nib, 16'd0};
          acc_d   = wide[CountBits-1:0];
          phase_d = PhCntMid;
        end else if (av_tag[TagShortBit]) begin
          wide    = {8'd0, nib, 8'd0};
          acc_d   = wide[CountBits-1:0];
          phase_d = PhCntLow;
        end else begin
          wide  = {16'd0, nib};
          acc_d = wide[CountBits-1:0];
          if (acc_d != '0) begin
            have  = 1'b1;
            o_val = run_d;
            o_cnt = CountW'(acc_d);
          end
          phase_d = PhTag;
        end
      end
    end else begin
      have  = 1'b1;
      o_val = b;
      o_cnt = CountW'(1);
    end

    // final byte closes the stream
    if (s1_data_q.end_of_stream) begin
      err     = mode_q && (phase_d != PhTag);
      phase_d = PhTag;
      lit_d   = '0;
      acc_d   = '0;
      have    = 1'b1;
    end

    out_valid_d             = have;
    out_data_d.fill_value   = o_val;
    out_data_d.repeat_count = o_cnt;
    out_data_d.stream_done  = s1_data_q.end_of_stream;
    out_data_d.stream_error = err;
  end

  // control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= CompressedModeRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PhTag;
      tag_q       <= 8'd0;
      acc_q       <= '0;
      run_q       <= 8'd0;
      lit_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q && out_valid_d;
      end
      if (advance) begin
        phase_q <= phase_d;
        tag_q   <= tag_d;
        acc_q   <= acc_d;
        run_q   <= run_d;
        lit_q   <= lit_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (advance && out_valid_d) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

// File: rtl/core/rle_port_checker.sv
// Port-level checks for rle_token_stream_decoder, bound to the top level.
// Depends on rle_pkg.
module rle_port_checker
  import rle_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input rle_out_t out_data_o
);

  // a stalled result stays shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // an error is only flagged on the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stream_error |-> out_data_o.stream_done)
    else $error("error without stream end");

  // a zero count only comes from an empty end record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.repeat_count == '0) |-> out_data_o.stream_done)
    else $error("zero count on a non-final result");

  // input only backs up when the output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output free");

endmodule

bind rle_token_stream_decoder rle_port_checker u_rle_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: tb/rle_fill_checker.sv
// Result checker for the run-length token stream decoder: watches the byte,
// result and mode-register channels, predicts each fill word and compares.
// Depends on rle_pkg for the transfer types, widths and tag bit positions.
module rle_fill_checker
  import rle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  rle_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rle_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PhTag,
    PhValue,
    PhCountMid,
    PhCountLow,
    PhLitLow,
    PhLitData
  } parse_phase_e;

  localparam logic [7:0]        NibbleMask = 8'h0f;
  localparam logic [CountW-1:0] CountMask  = CountW'((64'd1 << CountBits) - 64'd1);
  localparam int unsigned       MaxReports = 10;

  // shadow of the decoder state and its mode register
  logic              comp_mode = CompressedModeRst;
  parse_phase_e      phase     = PhTag;
  logic [7:0]        tag_byte  = '0;
  logic [CountW-1:0] run_count = '0;
  logic [7:0]        run_byte  = '0;
  logic [LitW-1:0]   lit_left  = '0;

  // fill word produced by the byte being decoded
  logic              hit;
  logic [7:0]        hit_value;
  logic [CountW-1:0] hit_count;

  rle_out_t queued_fills[$];
  rle_out_t want;
  logic     bad;

  task automatic emit_word(input logic [7:0] value, input logic [CountW-1:0] count);
    hit       = 1'b1;
    hit_value = value;
    hit_count = count;
  endtask

  // a run with a zero count gives nothing
  task automatic close_run();
    run_count = run_count & CountMask;
    if (run_count != '0) emit_word(run_byte, run_count);
    phase = PhTag;
  endtask

  // the count width comes from the tag, the wide form wins over the short one
  task automatic load_count();
    logic [CountW-1:0] nib;
    nib = CountW'(tag_byte & NibbleMask);
    if (tag_byte[TagWideBit]) begin
      run_count = (nib << 16) & CountMask;
      phase     = PhCountMid;
    end else if (tag_byte[TagShortBit]) begin
      run_count = (nib << 8) & CountMask;
      phase     = PhCountLow;
    end else begin
      run_count = nib;
      close_run();
    end
  endtask

  // advance the shadow parser by one byte and queue the fill word it causes
  task automatic decode_byte(input rle_in_t item);
    logic [7:0] b;
    logic       cut;
    rle_out_t   fill;
    b         = item.data_byte;
    hit       = 1'b0;
    hit_value = '0;
    hit_count = '0;
    cut       = 1'b0;
    if (!comp_mode) begin
      emit_word(b, CountW'(1));
    end else begin
      case (phase)
        PhValue: begin
          run_byte = b;
          load_count();
        end
        PhCountMid: begin
          run_count = (run_count | (CountW'(b) << 8)) & CountMask;
          phase     = PhCountLow;
        end
        PhCountLow: begin
          run_count = (run_count | CountW'(b)) & CountMask;
          close_run();
        end
        PhLitLow: begin
          lit_left = lit_left | LitW'(b);
          if (lit_left != '0) phase = PhLitData;
          else phase = PhTag;
        end
        PhLitData: begin
          emit_word(b, CountW'(1));
          lit_left = lit_left - LitW'(1);
          if (lit_left == '0) phase = PhTag;
        end
        default: begin
          tag_byte = b;
          if (b[TagRunBit]) begin
            run_byte = '0;
            if (b[TagZeroBit]) load_count();
            else phase = PhValue;
          end else if (b[TagShortBit]) begin
            // literal bit 5 plays no part
            lit_left = LitW'(b & NibbleMask) << 8;
            phase    = PhLitLow;
          end else begin
            lit_left = LitW'(b & NibbleMask);
            if (lit_left != '0) phase = PhLitData;
            else phase = PhTag;
          end
        end
      endcase
    end
    // end of stream always answers and flags an open record
    if (item.end_of_stream) begin
      cut       = comp_mode && (phase != PhTag);
      phase     = PhTag;
      lit_left  = '0;
      run_count = '0;
      hit       = 1'b1;
    end
    if (hit) begin
      fill.fill_value   = hit_value;
      fill.repeat_count = hit_count;
      fill.stream_done  = item.end_of_stream;
      fill.stream_error = cut;
      queued_fills.push_back(fill);
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      comp_mode = CompressedModeRst;
      phase     = PhTag;
      tag_byte  = '0;
      run_count = '0;
      run_byte  = '0;
      lit_left  = '0;
      queued_fills.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) comp_mode = cfg_data_i;
      // result transfer against the oldest queued fill word
      if (out_valid_i && !out_stall_i) begin
        if (queued_fills.size() == 0) begin
          if (fail_count_o < MaxReports)
            $display("%0t: unexpected result value %02h count %05h done %b error %b",
                     $realtime, out_data_i.fill_value, out_data_i.repeat_count,
                     out_data_i.stream_done, out_data_i.stream_error);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = queued_fills.pop_front();
          bad  = (out_data_i.fill_value !== want.fill_value)
              || (out_data_i.repeat_count !== want.repeat_count)
              || (out_data_i.stream_done !== want.stream_done)
              || (out_data_i.stream_error !== want.stream_error);
          if (bad) begin
            if (fail_count_o < MaxReports) begin
              $write("%0t: mismatch exp value %02h count %05h done %b error %b, ",
                     $realtime, want.fill_value, want.repeat_count, want.stream_done,
                     want.stream_error);
              $display("got value %02h count %05h done %b error %b",
                       out_data_i.fill_value, out_data_i.repeat_count,
                       out_data_i.stream_done, out_data_i.stream_error);
            end
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) decode_byte(in_data_i);
    end
    pending_o = queued_fills.size();
  end

endmodule

// File: tb/tb_rle_token_stream_decoder.sv
// Testbench top for rle_token_stream_decoder: drives byte streams and mode
// writes with random idling and back-pressure; rle_fill_checker judges results.
// Depends on rle_pkg, rle_fill_checker and the decoder RTL.
module tb_rle_token_stream_decoder;
  import rle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          ClkHalf       = 10;
  localparam int          DrainCycles   = 6;
  localparam int unsigned WatchdogLimit = 1000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  rle_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  rle_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic     cfg_data_i;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent;
  logic        quiet;
  logic [7:0]  body_q[$];

  rle_token_stream_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  rle_fill_checker u_fill_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // result back-pressure in short bursts
  initial begin : result_backpressure
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // give up after a long stretch without any transfer
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_rle_token_stream_decoder: done, errors");
    $finish;
  end

  // one byte transfer, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, end_of_stream: eos};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_body(input logic eos_last);
    foreach (body_q[i]) send_byte(body_q[i], eos_last && (i == body_q.size() - 1));
  endtask

  // hold the sender until every queued fill word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one well-formed record with random content, long literals kept rare
  task automatic add_record();
    logic [7:0] tag;
    logic [7:0] lo;
    int         n;
    if ($urandom_range(0, 1) == 1) begin
      tag = {1'b1, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15))};
      body_q.push_back(tag);
      if (!tag[TagZeroBit]) body_q.push_back(8'($urandom));
      if (tag[TagWideBit]) begin
        body_q.push_back(8'($urandom));
        body_q.push_back(8'($urandom));
      end else if (tag[TagShortBit]) begin
        body_q.push_back(8'($urandom));
      end
    end else begin
      tag = {1'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15))};
      if (tag[TagShortBit]) begin
        if ($urandom_range(0, 15) != 0) tag[3:0] = 4'h0;
        else tag[3:0] = 4'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) lo = 8'($urandom);
        else lo = 8'($urandom_range(0, 12));
        n = {tag[3:0], lo};
        body_q.push_back(tag);
        body_q.push_back(lo);
      end else begin
        n = tag[3:0];
        body_q.push_back(tag);
      end
      repeat (n) body_q.push_back(8'($urandom));
    end
  endtask

  // a stream of records or noise, sometimes cut short, sometimes left open
  task automatic send_stream(input logic parse);
    logic eos;
    body_q.delete();
    if (!parse || $urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) add_record();
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) if (body_q.size() > 1) void'(body_q.pop_back());
    end
    eos = ($urandom_range(0, 5) != 0);
    send_body(eos);
  endtask

  task automatic run_phase(input logic mode, input int unsigned n);
    int unsigned target;
    logic        paused;
    write_mode(mode);
    target = bytes_sent + n;
    paused = 1'b0;
    while (bytes_sent < target) begin
      send_stream(mode);
      if (!paused && bytes_sent >= target - n / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    quiet       = 1'b0;
    bytes_sent  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed records in compressed mode: zero run, value run, wide count
    // with both width bits, short zero run at full count, empty run, empty
    // literal, literal with bits 6 and 5, empty and one-byte short literals
    body_q = {8'hC5, 8'h83, 8'hFF, 8'hBF, 8'hAA, 8'hFF, 8'hFF, 8'hDF, 8'hFF,
              8'h80, 8'h12, 8'h00, 8'h62, 8'h00, 8'hFF, 8'h10, 8'h00,
              8'h10, 8'h01, 8'h7E};
    send_body(1'b0);
    // end on a byte with its own result, on one without, and inside a record
    send_byte(8'hC1, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h83, 1'b1);
    // raw pass-through
    write_mode(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b1);

    // random streams across mode settings, the last part without idling
    run_phase(1'b1, 700);
    run_phase(1'b0, 300);
    run_phase(1'b1, 600);
    quiet = 1'b1;
    run_phase(1'b1, 400);

    wait_drained();
    if (fail_count == 0 && pending == 0)
      $display("tb_rle_token_stream_decoder: done, clean");
    else
      $display("tb_rle_token_stream_decoder: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rle_pkg.sv
rtl/core/rle_token_stream_decoder.sv
rtl/core/rle_port_checker.sv
tb/rle_fill_checker.sv
tb/tb_rle_token_stream_decoder.sv
